// ----- hw/rtl/swfn_pkg.sv -----
// Shared definitions for the sliding-window first-negative block.
// Holds the configuration word width; no dependencies.
package swfn_pkg;

	// Width of the window length configuration word
	localparam int CFG_W = 11;

endpackage

// ----- hw/rtl/sliding_window_first_negative.sv -----
// A sample word is captured into the sample_s1 stage register when it is accepted; its result
// word is loaded into the output register when that sample goes. Throughput: one sample per
// cycle while the output is not stalled; a mid-run shrink of window_len stalls input while stale
// queue entries beyond the first are dropped one at a time by the single queue memory port.
// Samples before the window fills give no result. A last_sample word clears the run.
// Reset (arst_n low) empties the queue and sets window_len to 1; queue memory is not cleared.
// Depends on swfn_pkg.
module sliding_window_first_negative #(
	parameter int WINDOW_MAX = 1024,
	parameter int DATA_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [DATA_WIDTH-1:0]        sample,
	input  logic                                last_sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [DATA_WIDTH-1:0]        first_negative,
	output logic                                has_negative,
	output logic                                window_last,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [swfn_pkg::CFG_W-1:0]          window_len
);

	localparam int IW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CW   = $clog2(WINDOW_MAX + 1);
	localparam int SPAN = 2 * WINDOW_MAX;
	localparam int PW   = $clog2(SPAN);

	typedef struct packed {
		logic [PW-1:0]                  pos;
		logic signed [DATA_WIDTH-1:0]   val;
	} entry_t;

	// Queue storage and its registered read port
	entry_t mem [WINDOW_MAX];
	entry_t rd_q;
	entry_t front_q;

	logic [IW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q, seen_q;
	logic [PW-1:0] pos_q;
	logic [swfn_pkg::CFG_W-1:0] wl_q;

	logic                          valid_s1;
	logic signed [DATA_WIDTH-1:0]  sample_s1;
	logic                          last_s1;

	logic                          out_valid_q;
	logic signed [DATA_WIDTH-1:0]  first_negative_q;
	logic                          has_negative_q;
	logic                          window_last_q;

	logic [CW-1:0] w_eff;
	logic          neg, exp0, exp1, trim, go, produce, out_room, push;
	logic [CW-1:0] seen_inc, cnt_a;
	logic signed [DATA_WIDTH-1:0] res_val;
	logic          res_has;
	entry_t        entry_new, front_n;
	logic [IW-1:0] head_n, tail_n, rd_addr;
	logic [CW-1:0] count_n, seen_n;
	logic [PW-1:0] pos_n;

	function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i);
		logic [IW-1:0] r;
		if (i == IW'(WINDOW_MAX - 1)) r = '0;
		else r = i + 1'b1;
		return r;
	endfunction

	function automatic logic [PW-1:0] pos_inc(input logic [PW-1:0] p);
		logic [PW-1:0] r;
		if (p == PW'(SPAN - 1)) r = '0;
		else r = p + 1'b1;
		return r;
	endfunction

	// Distance from a stored position to the current one, modulo the position span
	function automatic logic [PW-1:0] age_of(input logic [PW-1:0] now, input logic [PW-1:0] then_p);
		logic [PW:0] d;
		d = {1'b0, now} - {1'b0, then_p};
		if (d[PW]) d = d + (PW+1)'(SPAN);
		return d[PW-1:0];
	endfunction

	// Clamp the window length to 1..WINDOW_MAX
	always_comb begin
		if (wl_q == '0) begin
			w_eff = CW'(1);
		end else if (32'(wl_q) > WINDOW_MAX) begin
			w_eff = CW'(WINDOW_MAX);
		end else begin
			w_eff = CW'(wl_q);
		end
	end

	// Expiry of the two oldest entries against the pending sample's position
	assign exp0 = (count_q != '0) && (age_of(pos_q, front_q.pos) >= PW'(w_eff));
	assign exp1 = (count_q > CW'(1)) && (age_of(pos_q, rd_q.pos) >= PW'(w_eff));
	assign trim = valid_s1 && exp0 && exp1;

	assign neg       = sample_s1[DATA_WIDTH-1];
	assign seen_inc  = (seen_q == CW'(WINDOW_MAX)) ? seen_q : seen_q + 1'b1;
	assign produce   = (seen_inc >= w_eff);
	assign out_room  = !out_valid_q || out_ready;
	assign go        = valid_s1 && !trim && (!produce || out_room);
	assign push      = go && neg;
	assign in_ready  = !valid_s1 || go;
	assign cfg_ready = 1'b1;
	assign cnt_a     = count_q - CW'(exp0);

	assign entry_new.pos = pos_q;
	assign entry_new.val = sample_s1;

	// Pick the oldest negative left in the window after this sample
	always_comb begin
		if (cnt_a != '0) begin
			res_val = exp0 ? rd_q.val : front_q.val;
			res_has = 1'b1;
		end else if (neg) begin
			res_val = sample_s1;
			res_has = 1'b1;
		end else begin
			res_val = '0;
			res_has = 1'b0;
		end
	end

	// Advance queue pointers, cached front entry and run counters
	always_comb begin
		head_n  = head_q;
		tail_n  = tail_q;
		count_n = count_q;
		pos_n   = pos_q;
		seen_n  = seen_q;
		front_n = front_q;
		if (trim) begin
			head_n  = idx_inc(head_q);
			count_n = count_q - 1'b1;
			front_n = rd_q;
		end else if (go) begin
			if (exp0) head_n = idx_inc(head_q);
			if (exp0 && cnt_a != '0) begin
				front_n = rd_q;
			end else if (cnt_a == '0 && neg) begin
				front_n = entry_new;
			end
			if (push) tail_n = idx_inc(tail_q);
			count_n = cnt_a + CW'(push);
			pos_n   = pos_inc(pos_q);
			seen_n  = seen_inc;
			if (last_s1) begin
				head_n  = '0;
				tail_n  = '0;
				count_n = '0;
				pos_n   = '0;
				seen_n  = '0;
			end
		end
	end

	assign rd_addr = idx_inc(head_n);

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			pos_q       <= '0;
			seen_q      <= '0;
			wl_q        <= swfn_pkg::CFG_W'(1);
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			head_q  <= head_n;
			tail_q  <= tail_n;
			count_q <= count_n;
			pos_q   <= pos_n;
			seen_q  <= seen_n;
			if (cfg_valid && cfg_ready) wl_q <= window_len;
			if (in_ready) valid_s1 <= in_valid;
			if (go && produce) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture input and result words
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			sample_s1 <= sample;
			last_s1   <= last_sample;
		end
		if (go && produce) begin
			first_negative_q <= res_val;
			has_negative_q   <= res_has;
			window_last_q    <= last_s1;
		end
		front_q <= front_n;
	end

	// Queue memory: write at tail, read the entry behind the next head, bypass a same-cycle write
	always_ff @(posedge clk) begin
		if (push) mem[tail_q] <= entry_new;
		if (push && tail_q == rd_addr) begin
			rd_q <= entry_new;
		end else begin
			rd_q <= mem[rd_addr];
		end
	end

	assign out_valid      = out_valid_q;
	assign first_negative = first_negative_q;
	assign has_negative   = has_negative_q;
	assign window_last    = window_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(WINDOW_MAX))
		else $error("queue count above capacity");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		go && last_s1 |=> count_q == '0 && seen_q == '0 && pos_q == '0)
		else $error("run state not cleared after last sample");

	a_result_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (has_negative_q == first_negative_q[DATA_WIDTH-1])
			&& (has_negative_q || first_negative_q == '0))
		else $error("result value disagrees with negative flag");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> head_q == tail_q)
		else $error("empty queue with head and tail apart");

	a_trim_holds: assert property (@(posedge clk) disable iff (!arst_n)
		trim |=> valid_s1)
		else $error("pending sample lost while dropping stale entries");

endmodule
